// ===== hw/rtl/lmcf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmcf_pkg
// Shared types, codes and the control store of the LED matrix chain framer.
// ----------------------------------------------------------------------------
package lmcf_pkg;

	// command codes
	typedef logic [2:0] op_t;
	localparam op_t OP_INIT  = 3'd0;
	localparam op_t OP_CLEAR = 3'd1;
	localparam op_t OP_SET   = 3'd2;
	localparam op_t OP_ROW   = 3'd3;
	localparam op_t OP_GET   = 3'd4;

	// driver register addresses
	localparam logic [3:0] REG_NOOP      = 4'h0;
	localparam logic [3:0] REG_DIGIT_1   = 4'h1;
	localparam logic [3:0] REG_DIGIT_8   = 4'h8;
	localparam logic [3:0] REG_DECODE    = 4'h9;
	localparam logic [3:0] REG_INTENSITY = 4'hA;
	localparam logic [3:0] REG_SCAN      = 4'hB;
	localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
	localparam logic [3:0] REG_TEST      = 4'hF;

	localparam logic [7:0] DATA_ZERO = 8'h00;
	localparam logic [7:0] DATA_ONE  = 8'h01;

	// configuration register indexes
	localparam logic CFG_INTENSITY = 1'b0;
	localparam logic CFG_SCAN      = 1'b1;

	// datapath selects
	typedef enum logic [1:0] {AS_ZERO, AS_CONST, AS_DIGIT, AS_TGT} addr_sel_t;
	typedef enum logic [2:0] {
		DS_ZERO, DS_ONE, DS_INTENSITY, DS_SCAN, DS_PIX_TGT, DS_ROW_TGT
	} data_sel_t;
	typedef enum logic [1:0] {LP_NONE, LP_POS, LP_POS_DIG, LP_COL} loop_t;
	typedef enum logic [1:0] {MEM_NONE, MEM_RD, MEM_WR_PIX, MEM_WR_ROW} mem_op_t;

	// program steps
	typedef logic [3:0] step_t;
	localparam step_t S_IDLE      = 4'd0;
	localparam step_t S_INIT_TEST = 4'd1;
	localparam step_t S_INIT_SHDN = 4'd2;
	localparam step_t S_INIT_INT  = 4'd3;
	localparam step_t S_INIT_SCAN = 4'd4;
	localparam step_t S_INIT_DEC  = 4'd5;
	localparam step_t S_CLR       = 4'd6;
	localparam step_t S_PX_RD     = 4'd7;
	localparam step_t S_PX_WR     = 4'd8;
	localparam step_t S_PX_FRM    = 4'd9;
	localparam step_t S_ROW_WR    = 4'd10;
	localparam step_t S_ROW_FRM   = 4'd11;
	localparam step_t S_GP_RD     = 4'd12;
	localparam step_t S_GP_OUT    = 4'd13;

	// one control word
	typedef struct packed {
		logic       emit;
		addr_sel_t  asel;
		logic [3:0] addr;
		data_sel_t  dsel;
		logic       pix_out;
		loop_t      loop;
		mem_op_t    mem;
		step_t      nxt;
	} ctrl_t;

	// control store
	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		c.emit    = 1'b0;
		c.asel    = AS_ZERO;
		c.addr    = REG_NOOP;
		c.dsel    = DS_ZERO;
		c.pix_out = 1'b0;
		c.loop    = LP_NONE;
		c.mem     = MEM_NONE;
		c.nxt     = S_IDLE;
		case (s)
			S_INIT_TEST: begin
				c.emit = 1'b1; c.asel = AS_CONST; c.addr = REG_TEST;
				c.loop = LP_POS; c.nxt = S_INIT_SHDN;
			end
			S_INIT_SHDN: begin
				c.emit = 1'b1; c.asel = AS_CONST; c.addr = REG_SHUTDOWN;
				c.dsel = DS_ONE; c.loop = LP_POS; c.nxt = S_INIT_INT;
			end
			S_INIT_INT: begin
				c.emit = 1'b1; c.asel = AS_CONST; c.addr = REG_INTENSITY;
				c.dsel = DS_INTENSITY; c.loop = LP_POS; c.nxt = S_INIT_SCAN;
			end
			S_INIT_SCAN: begin
				c.emit = 1'b1; c.asel = AS_CONST; c.addr = REG_SCAN;
				c.dsel = DS_SCAN; c.loop = LP_POS; c.nxt = S_INIT_DEC;
			end
			S_INIT_DEC: begin
				c.emit = 1'b1; c.asel = AS_CONST; c.addr = REG_DECODE;
				c.loop = LP_POS; c.nxt = S_CLR;
			end
			S_CLR: begin
				c.emit = 1'b1; c.asel = AS_DIGIT; c.loop = LP_POS_DIG; c.nxt = S_IDLE;
			end
			S_PX_RD: begin
				c.mem = MEM_RD; c.nxt = S_PX_WR;
			end
			S_PX_WR: begin
				c.mem = MEM_WR_PIX; c.nxt = S_PX_FRM;
			end
			S_PX_FRM: begin
				c.emit = 1'b1; c.asel = AS_TGT; c.dsel = DS_PIX_TGT;
				c.loop = LP_POS; c.nxt = S_IDLE;
			end
			S_ROW_WR: begin
				c.mem = MEM_WR_ROW; c.loop = LP_COL; c.nxt = S_ROW_FRM;
			end
			S_ROW_FRM: begin
				c.emit = 1'b1; c.asel = AS_TGT; c.dsel = DS_ROW_TGT;
				c.loop = LP_POS; c.nxt = S_IDLE;
			end
			S_GP_RD: begin
				c.mem = MEM_RD; c.nxt = S_GP_OUT;
			end
			S_GP_OUT: begin
				c.emit = 1'b1; c.pix_out = 1'b1; c.nxt = S_IDLE;
			end
			default: begin
				c.nxt = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lmcf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lmcf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lmcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/led_matrix_chain_framer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_chain_framer
// Frame buffer and word framer for a chain of 8x8 LED matrix driver chips,
// run by a small microcoded sequencer over a plain datapath.
// ----------------------------------------------------------------------------
// Sequence: init and clear load their first word into the output register
// straight from their entry step; set pixel first reads and rewrites the
// buffer byte, set row writes one buffer row per matrix column, and get
// pixel reads the buffer before its word. Words then leave one per cycle
// unless stalled. Each command returns the step counter to idle, and only
// there is the next command taken; in_stall is high while a program runs.
// Reset: arst_n clears control state and the per-row valid bits at once, so
// the frame buffer reads as zeros; intensity resets to 15, scan limit to 7.
module led_matrix_chain_framer #(
	parameter int MATRICES_X   = 4,
	parameter int MATRICES_Y   = 1,
	parameter int CHAIN_LENGTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// command channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire lmcf_pkg::op_t     op,
	input  wire logic [7:0]        x,
	input  wire logic [7:0]        y,
	input  wire logic              pixel_on,
	input  wire logic [7:0]        row_byte_0,
	input  wire logic [7:0]        row_byte_1,
	input  wire logic [7:0]        row_byte_2,
	input  wire logic [7:0]        row_byte_3,
	// word channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [3:0]        reg_address,
	output logic      [7:0]        reg_data,
	output logic      [1:0]        chain_position,
	output logic                   frame_last,
	output logic                   run_last,
	output logic                   pixel_value
);

	import lmcf_pkg::*;

	localparam int NUM_MAT   = MATRICES_X * MATRICES_Y;
	localparam int ROW_COUNT = NUM_MAT * 8;
	localparam int IDX_W     = $clog2(ROW_COUNT);
	localparam int COL_W     = (MATRICES_X > 1) ? $clog2(MATRICES_X) : 1;
	localparam int BAND_W    = (MATRICES_Y > 1) ? $clog2(MATRICES_Y) : 1;
	localparam int POS_W     = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
	localparam int CMP_W     = $clog2(NUM_MAT + CHAIN_LENGTH + 1);
	localparam logic [7:0]       LAST_COL = 8'(MATRICES_X * 8 - 1);
	localparam logic [7:0]       LAST_ROW = 8'(MATRICES_Y * 8 - 1);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(CHAIN_LENGTH - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MATRICES_X - 1);

	// configuration registers
	logic [3:0] intensity_q;
	logic [2:0] scan_limit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intensity_q  <= 4'd15;
			scan_limit_q <= 3'd7;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				CFG_INTENSITY: intensity_q  <= pwdata[3:0];
				CFG_SCAN:      scan_limit_q <= pwdata[2:0];
				default:       intensity_q  <= intensity_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			CFG_INTENSITY: prdata = {28'd0, intensity_q};
			CFG_SCAN:      prdata = {29'd0, scan_limit_q};
			default:       prdata = 32'd0;
		endcase
	end

	// sequencer state
	step_t            pc_q;
	logic [POS_W-1:0] pos_q;
	logic [3:0]       digit_q;
	logic [COL_W-1:0] colc_q;
	logic             out_valid_q;

	// latched command operands
	logic [CMP_W-1:0] m_q;
	logic [CMP_W-1:0] base_q;
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       row_q;
	logic [2:0]       xbit_q;
	logic             pix_q;
	logic [7:0]       rows_q [4];
	logic [7:0]       byte_q;

	ctrl_t cw;
	logic  in_acc;
	logic  out_free;
	logic  go;
	logic  pos_last;
	logic  col_last;
	logic  dig_last;
	logic  done;
	step_t entry;

	assign cw       = ucode(pc_q);
	assign in_stall = (pc_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign go       = !cw.emit || out_free;
	assign pos_last = (pos_q == POS_LAST);
	assign col_last = (colc_q == COL_LAST);
	assign dig_last = (digit_q == REG_DIGIT_8);

	// loop termination
	always_comb begin
		case (cw.loop)
			LP_NONE:    done = 1'b1;
			LP_POS:     done = pos_last;
			LP_POS_DIG: done = pos_last && dig_last;
			LP_COL:     done = col_last;
			default:    done = 1'b1;
		endcase
	end

	// program entry per command
	always_comb begin
		case (op)
			OP_INIT:  entry = S_INIT_TEST;
			OP_CLEAR: entry = S_CLR;
			OP_SET:   entry = S_PX_RD;
			OP_ROW:   entry = S_ROW_WR;
			OP_GET:   entry = S_GP_RD;
			default:  entry = S_IDLE;
		endcase
	end

	// coordinate clamping and matrix index
	logic [7:0]        x_cl;
	logic [7:0]        y_cl;
	logic [COL_W-1:0]  col_in;
	logic [BAND_W-1:0] band_in;
	logic [CMP_W-1:0]  base_in;
	logic [CMP_W-1:0]  m_in;

	assign x_cl    = (x > LAST_COL) ? LAST_COL : x;
	assign y_cl    = (y > LAST_ROW) ? LAST_ROW : y;
	assign col_in  = x_cl[COL_W+2:3];
	assign band_in = y_cl[BAND_W+2:3];
	assign base_in = CMP_W'(MATRICES_X) * CMP_W'(band_in);
	assign m_in    = base_in + CMP_W'(col_in);

	// operand capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_q       <= m_in;
			base_q    <= base_in;
			idx_q     <= IDX_W'({m_in, y_cl[2:0]});
			row_q     <= y_cl[2:0];
			xbit_q    <= x_cl[2:0];
			pix_q     <= pixel_on;
			rows_q[0] <= row_byte_0;
			rows_q[1] <= row_byte_1;
			rows_q[2] <= row_byte_2;
			rows_q[3] <= row_byte_3;
		end
	end

	// step counter and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= S_IDLE;
			pos_q   <= '0;
			digit_q <= REG_DIGIT_1;
			colc_q  <= '0;
		end else if (pc_q == S_IDLE) begin
			if (in_acc) begin
				pc_q    <= entry;
				pos_q   <= '0;
				digit_q <= REG_DIGIT_1;
				colc_q  <= '0;
			end
		end else if (go) begin
			case (cw.loop)
				LP_POS: begin
					pos_q <= pos_last ? '0 : pos_q + 1'b1;
				end
				LP_POS_DIG: begin
					pos_q <= pos_last ? '0 : pos_q + 1'b1;
					if (pos_last) begin
						digit_q <= digit_q + 4'd1;
					end
				end
				LP_COL: begin
					colc_q <= col_last ? '0 : colc_q + 1'b1;
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
			if (done) begin
				pc_q <= cw.nxt;
			end
		end
	end

	// frame buffer with per-row valid bits
	logic [ROW_COUNT-1:0] valid_q;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [7:0]           ram_wdata;
	logic                 ram_re;
	logic [7:0]           ram_rdata;
	logic [7:0]           cur_byte;
	logic [7:0]           bit_mask;
	logic [7:0]           new_byte;
	logic [CMP_W-1:0]     wr_mat;

	assign cur_byte = valid_q[idx_q] ? ram_rdata : 8'd0;
	assign bit_mask = 8'd1 << xbit_q;
	assign new_byte = pix_q ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
	assign wr_mat   = base_q + CMP_W'(colc_q);
	assign ram_re   = go && (cw.mem == MEM_RD);

	always_comb begin
		case (cw.mem)
			MEM_WR_PIX: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = new_byte;
			end
			MEM_WR_ROW: begin
				ram_we    = 1'b1;
				ram_waddr = IDX_W'({wr_mat, row_q});
				ram_wdata = rows_q[2'(colc_q)];
			end
			default: begin
				ram_we    = 1'b0;
				ram_waddr = idx_q;
				ram_wdata = new_byte;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.mem == MEM_WR_PIX) begin
			byte_q <= new_byte;
		end
	end

	lmcf_ram #(
		.WIDTH (8),
		.DEPTH (ROW_COUNT)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// target decode for one chain position
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] pos_off;
	logic             tgt;
	logic [7:0]       tgt_byte;

	assign pos_ext = CMP_W'(pos_q);
	assign pos_off = pos_ext - base_q;

	always_comb begin
		case (cw.dsel)
			DS_PIX_TGT: begin
				tgt      = (pos_ext == m_q);
				tgt_byte = byte_q;
			end
			DS_ROW_TGT: begin
				tgt      = (pos_ext >= base_q) &&
				           (pos_ext < base_q + CMP_W'(MATRICES_X));
				tgt_byte = rows_q[pos_off[1:0]];
			end
			default: begin
				tgt      = 1'b0;
				tgt_byte = DATA_ZERO;
			end
		endcase
	end

	// word assembly
	logic [3:0] word_addr;
	logic [7:0] word_data;

	always_comb begin
		case (cw.asel)
			AS_CONST: word_addr = cw.addr;
			AS_DIGIT: word_addr = digit_q;
			AS_TGT:   word_addr = tgt ? {1'b0, row_q} + 4'd1 : REG_NOOP;
			default:  word_addr = REG_NOOP;
		endcase
		case (cw.dsel)
			DS_ONE:       word_data = DATA_ONE;
			DS_INTENSITY: word_data = {4'd0, intensity_q};
			DS_SCAN:      word_data = {5'd0, scan_limit_q};
			DS_PIX_TGT,
			DS_ROW_TGT:   word_data = tgt ? tgt_byte : DATA_ZERO;
			default:      word_data = DATA_ZERO;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.emit && go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.emit && go) begin
			reg_address    <= word_addr;
			reg_data       <= word_data;
			chain_position <= 2'(pos_q);
			frame_last     <= ((cw.loop == LP_POS) || (cw.loop == LP_POS_DIG)) && pos_last;
			run_last       <= done && (cw.nxt == S_IDLE);
			pixel_value    <= cw.pix_out && cur_byte[xbit_q];
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_cmd_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (op == OP_INIT || op == OP_CLEAR || op == OP_SET ||
		            op == OP_ROW || op == OP_GET)) |=> (pc_q != S_IDLE))
		else $error("known command did not start a program");

	a_pixel_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pixel_value) |-> (run_last && !frame_last))
		else $error("pixel value outside a get pixel result");

	a_run_end_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && run_last && !frame_last) |->
		(reg_address == REG_NOOP && reg_data == DATA_ZERO && chain_position == 2'd0))
		else $error("run ended in the middle of a frame");

	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (chain_position == 2'(POS_LAST)))
		else $error("frame ended at wrong chain position");

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != S_IDLE) |-> !in_acc)
		else $error("command taken while a program runs");

endmodule
`default_nettype wire
